/* hw/rtl/tcptb_pkg.sv */
package tcptb_pkg;

  localparam int CONNECTIONS     = 16;
  localparam int TIMERS_PER_CONN = 4;
  localparam int CONN_W          = $clog2(CONNECTIONS);
  localparam int TIMER_W         = 2;
  localparam int COUNT_W         = 15;
  localparam int BACKOFF_W       = 16;
  localparam int XCLK_W          = 16;
  localparam int SEQ_W           = 32;
  localparam int NRES_W          = 3;   // 0 .. TIMERS_PER_CONN results
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 32;

  localparam logic [BACKOFF_W-1:0] MAX_BACKOFF_RST = 16'd240;
  localparam logic [SEQ_W-1:0]     ISS_STEP_RST    = 32'd64000;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_SET    = 3'd1,
    ACT_CANCEL = 3'd2,
    ACT_LOAD   = 3'd3,
    ACT_SWEEP  = 3'd4
  } action_e;

  typedef enum logic [TIMER_W-1:0] {
    TMR_FIN_ACK = 2'd0,
    TMR_REXMT   = 2'd1,
    TMR_GIVE_UP = 2'd2,
    TMR_PERSIST = 2'd3
  } timer_e;

  typedef enum logic [1:0] {
    CS_OTHER     = 2'd0,
    CS_TIME_WAIT = 2'd1,
    CS_CLOSING   = 2'd2
  } conn_state_e;

  typedef enum logic [2:0] {
    VD_SAME        = 3'd0,
    VD_DISCONNECT  = 3'd1,
    VD_RECV_WAIT   = 3'd2,
    VD_MARK_WAITED = 3'd3,
    VD_RETRANSMIT  = 3'd4,
    VD_TIMEOUT     = 3'd5,
    VD_FORCE_BYTE  = 3'd6,
    VD_SWEEP_DONE  = 3'd7
  } verdict_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_BACKOFF = 1'b0,
    CFG_ISS_STEP    = 1'b1
  } cfg_reg_e;

  typedef logic [COUNT_W-1:0] count_t;
  typedef count_t [TIMERS_PER_CONN-1:0] row_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [CONN_W-1:0]  connection;
    logic [TIMER_W-1:0] timer_index;
    count_t             timer_value;
    logic [1:0]         conn_state;
    logic               receive_empty;
    logic [SEQ_W-1:0]   rexmt_mark;
    logic [SEQ_W-1:0]   give_up_mark;
    logic [SEQ_W-1:0]   send_unacked;
  } item_t;

  typedef struct packed {
    logic [TIMER_W-1:0]   kind;
    verdict_e             verdict;
    logic [BACKOFF_W-1:0] backoff;
  } res_t;

  typedef struct packed {
    logic [NRES_W-1:0]           n_res;
    res_t [TIMERS_PER_CONN-1:0]  res;
    logic                        wr_row;
    row_t                        row;
    logic                        wr_backoff;
    logic [BACKOFF_W-1:0]        backoff;
    logic                        wr_xclk;
    logic [XCLK_W-1:0]           xclk;
    logic                        wr_iss;
    logic [SEQ_W-1:0]            iss;
  } eval_t;

  typedef struct packed {
    logic valid;   // a result is on the ports this cycle
    logic many;    // more than one result still to go
  } q_status_t;

  // modular sequence order: a strictly after b
  function automatic logic seq_after(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[SEQ_W-1];
  endfunction

endpackage

/* hw/rtl/tcptb_eval.sv */
module tcptb_eval import tcptb_pkg::*; (
  input  item_t                item_i,
  input  row_t                 row_i,
  input  logic [BACKOFF_W-1:0] backoff_i,
  input  logic [XCLK_W-1:0]    xclk_i,
  input  logic [SEQ_W-1:0]     iss_i,
  input  logic [BACKOFF_W-1:0] max_backoff_i,
  input  logic [SEQ_W-1:0]     iss_step_i,
  output eval_t                ev_o
);

  always_comb begin
    row_t                 row;
    logic [BACKOFF_W-1:0] boff;
    logic [BACKOFF_W:0]   dbl;
    logic [NRES_W-1:0]    n;
    verdict_e             v;
    logic                 cl;

    row  = row_i;
    boff = backoff_i;
    dbl  = '0;
    n    = '0;
    v    = VD_SAME;
    cl   = 1'b0;
    ev_o = '0;
    ev_o.xclk = xclk_i;
    ev_o.iss  = iss_i;

    case (action_e'(item_i.action))
      ACT_TICK: begin
        // timers in index order; a close clears the row so later ones stay quiet
        for (int t = 0; t < TIMERS_PER_CONN; t++) begin
          if (row[t] != '0) begin
            row[t] = row[t] - count_t'(1);
            if (row[t] == '0) begin
              v  = VD_SAME;
              cl = 1'b0;
              case (timer_e'(TIMER_W'(t)))
                TMR_FIN_ACK: begin
                  case (conn_state_e'(item_i.conn_state))
                    CS_TIME_WAIT: begin
                      v  = item_i.receive_empty ? VD_DISCONNECT : VD_RECV_WAIT;
                      cl = item_i.receive_empty;
                    end
                    CS_CLOSING: v = VD_MARK_WAITED;
                    default:    v = VD_SAME;
                  endcase
                end
                TMR_REXMT: begin
                  if (seq_after(item_i.rexmt_mark, item_i.send_unacked)) begin
                    dbl  = {boff, 1'b0};
                    boff = (dbl > {1'b0, max_backoff_i}) ? max_backoff_i : dbl[BACKOFF_W-1:0];
                    v    = VD_RETRANSMIT;
                  end
                end
                TMR_GIVE_UP: begin
                  if (seq_after(item_i.give_up_mark, item_i.send_unacked)) begin
                    v  = VD_TIMEOUT;
                    cl = 1'b1;
                  end
                end
                default: v = VD_FORCE_BYTE;
              endcase
              ev_o.res[n[TIMER_W-1:0]] = '{kind: TIMER_W'(t), verdict: v, backoff: boff};
              n = n + NRES_W'(1);
              if (cl) begin
                row = '0;
              end
            end
          end
        end
        if (n == '0) begin
          ev_o.res[0] = '{kind: TMR_FIN_ACK, verdict: VD_SAME, backoff: boff};
          n = NRES_W'(1);
        end
        ev_o.wr_row     = 1'b1;
        ev_o.wr_backoff = 1'b1;
        ev_o.wr_xclk    = 1'b1;
        ev_o.xclk       = xclk_i + XCLK_W'(1);
      end
      ACT_SET: begin
        row[item_i.timer_index] = item_i.timer_value;
        ev_o.wr_row = 1'b1;
        ev_o.res[0] = '{kind: item_i.timer_index, verdict: VD_SAME, backoff: boff};
        n = NRES_W'(1);
      end
      ACT_CANCEL: begin
        row = '0;
        ev_o.wr_row = 1'b1;
        ev_o.res[0] = '{kind: TMR_FIN_ACK, verdict: VD_SAME, backoff: boff};
        n = NRES_W'(1);
      end
      ACT_LOAD: begin
        boff = BACKOFF_W'(item_i.timer_value);
        ev_o.wr_backoff = 1'b1;
        ev_o.res[0] = '{kind: TMR_FIN_ACK, verdict: VD_SAME, backoff: boff};
        n = NRES_W'(1);
      end
      ACT_SWEEP: begin
        ev_o.wr_iss = 1'b1;
        ev_o.iss    = iss_i + iss_step_i;
        ev_o.res[0] = '{kind: TMR_FIN_ACK, verdict: VD_SWEEP_DONE, backoff: boff};
        n = NRES_W'(1);
      end
      default: n = '0;   // unused codes: dropped
    endcase

    ev_o.row     = row;
    ev_o.backoff = boff;
    ev_o.n_res   = n;
  end

endmodule

/* hw/rtl/tcptb_res_queue.sv */
module tcptb_res_queue import tcptb_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic [NRES_W-1:0]          n_res_i,
  input  res_t [TIMERS_PER_CONN-1:0] res_i,
  input  logic [CONN_W-1:0]          conn_i,
  input  logic [XCLK_W-1:0]          xclk_i,
  input  logic [SEQ_W-1:0]           iss_i,
  output q_status_t                  status_o,
  output logic [CONN_W-1:0]          out_connection_o,
  output logic [TIMER_W-1:0]         timer_kind_o,
  output logic [2:0]                 verdict_o,
  output logic [BACKOFF_W-1:0]       backoff_o,
  output logic [XCLK_W-1:0]          xmit_clock_o,
  output logic [SEQ_W-1:0]           iss_value_o,
  output logic                       last_o
);

  res_t [TIMERS_PER_CONN-1:0] ent_q;
  logic [CONN_W-1:0]          conn_q;
  logic [XCLK_W-1:0]          xclk_q;
  logic [SEQ_W-1:0]           iss_q;
  logic [TIMER_W-1:0]         rd_q, rd_d;
  logic [NRES_W-1:0]          cnt_q, cnt_d;

  always_comb begin
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (load_i) begin
      rd_d  = '0;
      cnt_d = n_res_i;
    end else if (cnt_q != '0) begin
      rd_d  = rd_q + TIMER_W'(1);
      cnt_d = cnt_q - NRES_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q  <= res_i;
      conn_q <= conn_i;
      xclk_q <= xclk_i;
      iss_q  <= iss_i;
    end
  end

  assign status_o.valid   = (cnt_q != '0);
  assign status_o.many    = (cnt_q > NRES_W'(1));
  assign out_connection_o = conn_q;
  assign timer_kind_o     = ent_q[rd_q].kind;
  assign verdict_o        = ent_q[rd_q].verdict;
  assign backoff_o        = ent_q[rd_q].backoff;
  assign xmit_clock_o     = xclk_q;
  assign iss_value_o      = iss_q;
  assign last_o           = (cnt_q == NRES_W'(1));

  // a new burst never overwrites one that still has results to give
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (cnt_q <= NRES_W'(1)))
    else $error("result queue loaded while results pending");

  // a burst that is not finished carries on in the next cycle
  a_burst_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_o.valid && !last_o) |=> status_o.valid)
    else $error("result burst broken off before last");

  // after the last result, a strobe only follows a fresh load
  a_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_o.valid && last_o) |=> (!status_o.valid || $past(load_i)))
    else $error("result emitted after last without new item");

  // never more results than timers
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NRES_W'(TIMERS_PER_CONN))
    else $error("result count out of range");

endmodule

/* hw/rtl/tcp_connection_timer_bank_core.sv */
// Timer bank for sixteen TCP connections, four countdown timers each (fin-ack,
// retransmit, give-up, persist), plus per-connection backoff and transmit clock
// and one shared ISS counter. A request is taken at a clock edge with start high
// and busy low; it waits in the input register while more than one result of
// the one before is still to be shown, is worked out in a single pass against
// the connection's state, and its results are shown from the result register,
// one per cycle on a result_valid_o strobe, the final one flagged by last_o.
// The receiver cannot stall: every result is valid for exactly one cycle and
// must be taken then. A request giving one result (control actions, a quiet
// tick, end of sweep) lets a new one in every cycle; a tick with k expiries
// shows k results (at most four), and busy stays high while more than one is
// still to be shown. Action codes 5 to 7 are dropped with no result.
// Configuration writes (max_backoff index 0, iss_step index 1) are always
// ready and should only be made while the bank is idle.
module tcp_connection_timer_bank_core import tcptb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // request channel
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              action_i,
  input  logic [CONN_W-1:0]       connection_i,
  input  logic [TIMER_W-1:0]      timer_index_i,
  input  logic [COUNT_W-1:0]      timer_value_i,
  input  logic [1:0]              conn_state_i,
  input  logic                    receive_empty_i,
  input  logic [SEQ_W-1:0]        rexmt_mark_i,
  input  logic [SEQ_W-1:0]        give_up_mark_i,
  input  logic [SEQ_W-1:0]        send_unacked_i,
  // configuration write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  // results
  output logic                    result_valid_o,
  output logic [CONN_W-1:0]       out_connection_o,
  output logic [TIMER_W-1:0]      timer_kind_o,
  output logic [2:0]              verdict_o,
  output logic [BACKOFF_W-1:0]    backoff_o,
  output logic [XCLK_W-1:0]       xmit_clock_o,
  output logic [SEQ_W-1:0]        iss_value_o,
  output logic                    last_o
);

  // input register
  item_t     item_q;
  logic      s1_valid_q, s1_valid_d;
  logic      accept, process;
  q_status_t q_status;
  eval_t     ev;

  // connection state
  row_t                 timer_q   [CONNECTIONS];
  logic [BACKOFF_W-1:0] backoff_q [CONNECTIONS];
  logic [XCLK_W-1:0]    xclk_q    [CONNECTIONS];
  logic [SEQ_W-1:0]     iss_q;

  // configuration
  logic [BACKOFF_W-1:0] max_backoff_q;
  logic [SEQ_W-1:0]     iss_step_q;

  // the held request moves on once at most the last result of the previous one
  // is on show; the input register is then free for a new request too
  assign busy    = q_status.many;
  assign accept  = start && !busy;
  assign process = s1_valid_q && !q_status.many;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (process) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{action:        action_i,
                  connection:    connection_i,
                  timer_index:   timer_index_i,
                  timer_value:   timer_value_i,
                  conn_state:    conn_state_i,
                  receive_empty: receive_empty_i,
                  rexmt_mark:    rexmt_mark_i,
                  give_up_mark:  give_up_mark_i,
                  send_unacked:  send_unacked_i};
    end
  end

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_backoff_q <= MAX_BACKOFF_RST;
      iss_step_q    <= ISS_STEP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_MAX_BACKOFF: max_backoff_q <= cfg_data_i[BACKOFF_W-1:0];
        CFG_ISS_STEP:    iss_step_q    <= cfg_data_i[SEQ_W-1:0];
        default:         ;
      endcase
    end
  end

  // single-pass evaluation against the addressed connection
  tcptb_eval u_eval (
    .item_i        (item_q),
    .row_i         (timer_q[item_q.connection]),
    .backoff_i     (backoff_q[item_q.connection]),
    .xclk_i        (xclk_q[item_q.connection]),
    .iss_i         (iss_q),
    .max_backoff_i (max_backoff_q),
    .iss_step_i    (iss_step_q),
    .ev_o          (ev)
  );

  // write-back; the slot field is exactly as wide as the bank, so every
  // connection number addresses a real slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CONNECTIONS; c++) begin
        timer_q[c]   <= '0;
        backoff_q[c] <= '0;
        xclk_q[c]    <= '0;
      end
      iss_q <= '0;
    end else if (process) begin
      if (ev.wr_row)     timer_q[item_q.connection]   <= ev.row;
      if (ev.wr_backoff) backoff_q[item_q.connection] <= ev.backoff;
      if (ev.wr_xclk)    xclk_q[item_q.connection]    <= ev.xclk;
      if (ev.wr_iss)     iss_q                        <= ev.iss;
    end
  end

  // result register: holds one request's results and shows them in turn
  tcptb_res_queue u_res_queue (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (process),
    .n_res_i          (ev.n_res),
    .res_i            (ev.res),
    .conn_i           (item_q.connection),
    .xclk_i           (ev.xclk),
    .iss_i            (ev.iss),
    .status_o         (q_status),
    .out_connection_o (out_connection_o),
    .timer_kind_o     (timer_kind_o),
    .verdict_o        (verdict_o),
    .backoff_o        (backoff_o),
    .xmit_clock_o     (xmit_clock_o),
    .iss_value_o      (iss_value_o),
    .last_o           (last_o)
  );

  assign result_valid_o = q_status.valid;

endmodule
